// ===== rtl/sops_pkg.sv =====
// shared types and constants for the segmented odd-only prime sieve
// used by sops_div and segmented_odd_prime_sieve; depends on nothing

package sops_pkg;

  localparam int unsigned MarkEntries = 65536;
  localparam int unsigned MarkAw      = $clog2(MarkEntries);
  localparam int unsigned EntW        = MarkAw + 1;
  localparam int unsigned DivW        = 41;
  localparam int unsigned DsrW        = 16;

  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_STRIKE = 2'd1,
    FUNC_COUNT  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_TOO_LARGE = 2'd1,
    STAT_TOO_MANY  = 2'd2,
    STAT_OVERRUN   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_LIMIT      = 2'd0,
    CFG_NODE_INDEX = 2'd1,
    CFG_NODE_COUNT = 2'd2
  } cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SU_DIV0,
    ST_SU_SQRT,
    ST_SU_DIV1,
    ST_SU_DIV2,
    ST_SU_EVAL,
    ST_CLEAR,
    ST_SK_CHK,
    ST_SK_DIV,
    ST_SK_MARK,
    ST_SC_CHK,
    ST_SC_WAIT,
    ST_SC_KEEP,
    ST_CN_CHK,
    ST_CN_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DsrW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quot;
    logic [DsrW-1:0] rem;
  } div_rsp_t;

endpackage

// ===== rtl/sops_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on sops_pkg for the request and response structs

module sops_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sops_pkg::div_req_t  req_i,
  output sops_pkg::div_rsp_t  rsp_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [5:0]                    cnt_q;
  logic [sops_pkg::DivW-1:0]     quot_q;
  logic [sops_pkg::DsrW-1:0]     rem_q;
  logic [sops_pkg::DsrW-1:0]     dsr_q;
  logic [sops_pkg::DsrW:0]       trial;
  logic [sops_pkg::DsrW:0]       diff;
  logic                          ge;

  assign trial = {rem_q, quot_q[sops_pkg::DivW-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= 6'(sops_pkg::DivW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quot_q <= req_i.dividend;
      rem_q  <= '0;
      dsr_q  <= req_i.divisor;
    end else if (busy_q) begin
      quot_q <= {quot_q[sops_pkg::DivW-2:0], ge};
      rem_q  <= ge ? diff[sops_pkg::DsrW-1:0] : trial[sops_pkg::DsrW-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== rtl/segmented_odd_prime_sieve.sv =====
// top level of one node of the segmented odd-only sieve of eratosthenes
// depends on sops_pkg and sops_div
//
// input beats (func_i, sieve_prime_i) are taken when in_valid_i is high and
// in_stall_o is low; in_stall_o is high while an item is being worked on.
// one result beat comes out per input beat, held on out_valid_o until
// out_stall_i is low. config writes (cfg_we_i, cfg_idx_i, cfg_data_i) are
// used by the start beat and by later strike and count beats, and are to be
// made only while the block is idle; the block itself does not enforce it.
// every item runs through one sequencer and one shared divider: start does
// its setup (three divisions and a square root), then clears the mark
// memory one segment entry per cycle; strike does its setup, strikes one
// mark per cycle, then on node 0 scans entries with a check and a wait
// state per entry, one memory read port; count also checks and waits on every entry.
// reset clears control state and sets limit 100, node 0 of 1 nodes with an
// empty segment; the mark memory is not cleared at reset since the start
// beat clears every entry that a later beat reads. a stalled receiver holds
// the result and the next item waits in the done state.

module segmented_odd_prime_sieve (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] sieve_prime_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] next_prime_o,
  output logic        keep_going_o,
  output logic [31:0] prime_count_o
);

  localparam int unsigned Aw = sops_pkg::MarkAw;
  localparam int unsigned Ew = sops_pkg::EntW;

  sops_pkg::state_e state_q, state_d;

  logic [31:0]   limit_q;
  logic [7:0]    node_idx_q;
  logic [8:0]    node_cnt_q;

  logic [15:0]   prime_q, prime_d;
  logic [32:0]   q0_q, q0_d, q1_q, q1_d, q2_q, q2_d;
  logic [15:0]   sqrt_q, sqrt_d;
  logic [3:0]    bit_q, bit_d;
  logic [32:0]   idx_q, idx_d;
  logic [31:0]   count_q, count_d;
  logic [17:0]   np_q, np_d;

  logic [1:0]    setup_q, setup_d;
  logic [33:0]   seg_first_q, seg_first_d;
  logic [Ew-1:0] seg_entries_q, seg_entries_d;
  logic [Ew-1:0] scan_pos_q, scan_pos_d;

  logic [1:0]    res_status_q, res_status_d;
  logic [31:0]   res_next_q, res_next_d;
  logic          res_keep_q, res_keep_d;
  logic [31:0]   res_count_q, res_count_d;

  logic          out_valid_q, out_valid_d;
  logic [1:0]    out_status_q;
  logic [31:0]   out_next_q;
  logic          out_keep_q;
  logic [31:0]   out_count_q;
  logic          out_load;

  logic          div_run_q, div_run_d;
  logic          div_go;
  sops_pkg::div_req_t div_req;
  sops_pkg::div_rsp_t div_rsp;

  logic          mark_mem [sops_pkg::MarkEntries];
  logic          mem_we;
  logic          mem_wdata;
  logic [Aw-1:0] mem_addr;
  logic          mem_rd_q;

  logic          in_acc;
  logic [31:0]   m_val;
  logic [8:0]    p_val;
  logic          node0;
  logic          idx_lt_ent;
  logic [15:0]   sq_cand;
  logic [31:0]   sq_prod;
  logic [31:0]   pp;
  logic          prime_bad;
  logic [33:0]   lo_odd;
  logic [33:0]   hi_val;
  logic [33:0]   ent_val;
  logic          err_many;
  logic          err_large;
  logic [16:0]   first_div;
  logic [35:0]   np_sq;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q    <= 32'd100;
      node_idx_q <= 8'd0;
      node_cnt_q <= 9'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sops_pkg::CFG_LIMIT:      limit_q    <= cfg_data_i;
        sops_pkg::CFG_NODE_INDEX: node_idx_q <= cfg_data_i[7:0];
        sops_pkg::CFG_NODE_COUNT: node_cnt_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- helpers
  assign in_stall_o = state_q != sops_pkg::ST_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign m_val      = (limit_q >= 32'd1) ? limit_q - 32'd1 : 32'd0;
  assign p_val      = (node_cnt_q == 9'd0) ? 9'd1 : node_cnt_q;
  assign node0      = node_idx_q == 8'd0;
  assign idx_lt_ent = idx_q < 33'(seg_entries_q);

  assign sq_cand = sqrt_q | (16'd1 << bit_q);
  assign sq_prod = 32'(sq_cand) * 32'(sq_cand);

  assign pp        = 32'(prime_q) * 32'(prime_q);
  assign prime_bad = (prime_q < 16'd3) || !prime_q[0];

  assign lo_odd  = (34'(q1_q) + 34'd2) | 34'd1;
  assign hi_val  = 34'(q2_q) + 34'd2;
  assign ent_val = (hi_val > lo_odd) ? ((hi_val - lo_odd + 34'd1) >> 1) : 34'd0;
  assign err_many  = (9'(node_idx_q) >= p_val) ||
                     ((34'(q0_q) + 34'd2) < 34'(sqrt_q));
  assign err_large = ent_val > 34'(sops_pkg::MarkEntries);

  always_comb begin
    first_div = 17'd0;
    if (div_rsp.rem != 16'd0) begin
      if (div_rsp.quot[0]) begin
        first_div = ({prime_q, 1'b0} - 17'(div_rsp.rem)) >> 1;
      end else begin
        first_div = (17'(prime_q) - 17'(div_rsp.rem)) >> 1;
      end
    end
  end

  assign np_sq = 36'(np_q) * 36'(np_q);

  // ---------------------------------------------------------------- divider
  assign div_go = !div_run_q && (state_q == sops_pkg::ST_SU_DIV0 ||
                                 state_q == sops_pkg::ST_SU_DIV1 ||
                                 state_q == sops_pkg::ST_SU_DIV2 ||
                                 state_q == sops_pkg::ST_SK_DIV);

  always_comb begin
    div_req.start    = div_go;
    div_req.divisor  = 16'(p_val);
    div_req.dividend = 41'(m_val);
    case (state_q)
      sops_pkg::ST_SU_DIV1: div_req.dividend = 41'(node_idx_q) * 41'(m_val);
      sops_pkg::ST_SU_DIV2: div_req.dividend = (41'(node_idx_q) + 41'd1) * 41'(m_val);
      sops_pkg::ST_SK_DIV: begin
        div_req.dividend = 41'(seg_first_q);
        div_req.divisor  = prime_q;
      end
      default: ;
    endcase
  end

  assign div_run_d = div_go ? 1'b1 : (div_rsp.done ? 1'b0 : div_run_q);

  sops_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sops_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (func_i == sops_pkg::FUNC_START) begin
            state_d = sops_pkg::ST_SU_DIV0;
          end else if (setup_q != sops_pkg::STAT_OK) begin
            state_d = sops_pkg::ST_DONE;
          end else if (func_i == sops_pkg::FUNC_STRIKE) begin
            state_d = sops_pkg::ST_SK_CHK;
          end else if (func_i == sops_pkg::FUNC_COUNT) begin
            state_d = sops_pkg::ST_CN_CHK;
          end else begin
            state_d = sops_pkg::ST_DONE;
          end
        end
      end
      sops_pkg::ST_SU_DIV0: if (div_rsp.done) state_d = sops_pkg::ST_SU_SQRT;
      sops_pkg::ST_SU_SQRT: if (bit_q == 4'd0) state_d = sops_pkg::ST_SU_DIV1;
      sops_pkg::ST_SU_DIV1: if (div_rsp.done) state_d = sops_pkg::ST_SU_DIV2;
      sops_pkg::ST_SU_DIV2: if (div_rsp.done) state_d = sops_pkg::ST_SU_EVAL;
      sops_pkg::ST_SU_EVAL: begin
        state_d = (err_many || err_large || ent_val == 34'd0) ?
                  sops_pkg::ST_DONE : sops_pkg::ST_CLEAR;
      end
      sops_pkg::ST_CLEAR: if (!idx_lt_ent) state_d = sops_pkg::ST_DONE;
      sops_pkg::ST_SK_CHK: begin
        if (prime_bad) begin
          state_d = node0 ? sops_pkg::ST_SC_CHK : sops_pkg::ST_DONE;
        end else if (34'(pp) > seg_first_q) begin
          state_d = sops_pkg::ST_SK_MARK;
        end else begin
          state_d = sops_pkg::ST_SK_DIV;
        end
      end
      sops_pkg::ST_SK_DIV: if (div_rsp.done) state_d = sops_pkg::ST_SK_MARK;
      sops_pkg::ST_SK_MARK: begin
        if (!idx_lt_ent) state_d = node0 ? sops_pkg::ST_SC_CHK : sops_pkg::ST_DONE;
      end
      sops_pkg::ST_SC_CHK: begin
        state_d = idx_lt_ent ? sops_pkg::ST_SC_WAIT : sops_pkg::ST_DONE;
      end
      sops_pkg::ST_SC_WAIT: begin
        state_d = mem_rd_q ? sops_pkg::ST_SC_CHK : sops_pkg::ST_SC_KEEP;
      end
      sops_pkg::ST_SC_KEEP: state_d = sops_pkg::ST_DONE;
      sops_pkg::ST_CN_CHK: begin
        state_d = idx_lt_ent ? sops_pkg::ST_CN_WAIT : sops_pkg::ST_DONE;
      end
      sops_pkg::ST_CN_WAIT: state_d = sops_pkg::ST_CN_CHK;
      sops_pkg::ST_DONE: if (out_load) state_d = sops_pkg::ST_IDLE;
      default: state_d = sops_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  assign out_load = (state_q == sops_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    prime_d       = prime_q;
    q0_d          = q0_q;
    q1_d          = q1_q;
    q2_d          = q2_q;
    sqrt_d        = sqrt_q;
    bit_d         = bit_q;
    idx_d         = idx_q;
    count_d       = count_q;
    np_d          = np_q;
    setup_d       = setup_q;
    seg_first_d   = seg_first_q;
    seg_entries_d = seg_entries_q;
    scan_pos_d    = scan_pos_q;
    res_status_d  = res_status_q;
    res_next_d    = res_next_q;
    res_keep_d    = res_keep_q;
    res_count_d   = res_count_q;
    mem_we        = 1'b0;
    mem_wdata     = 1'b0;
    case (state_q)
      sops_pkg::ST_IDLE: begin
        if (in_acc) begin
          prime_d      = sieve_prime_i;
          res_status_d = setup_q;
          res_next_d   = 32'd0;
          res_keep_d   = 1'b0;
          res_count_d  = 32'd0;
          idx_d        = 33'd0;
          count_d      = 32'd0;
          sqrt_d       = 16'd0;
          bit_d        = 4'd15;
        end
      end
      sops_pkg::ST_SU_DIV0: if (div_rsp.done) q0_d = div_rsp.quot[32:0];
      sops_pkg::ST_SU_SQRT: begin
        if (sq_prod <= limit_q) sqrt_d = sq_cand;
        bit_d = bit_q - 4'd1;
      end
      sops_pkg::ST_SU_DIV1: if (div_rsp.done) q1_d = div_rsp.quot[32:0];
      sops_pkg::ST_SU_DIV2: if (div_rsp.done) q2_d = div_rsp.quot[32:0];
      sops_pkg::ST_SU_EVAL: begin
        scan_pos_d = '0;
        idx_d      = 33'd0;
        res_next_d = node0 ? 32'd3 : 32'd0;
        res_keep_d = 1'b1;
        if (err_many) begin
          setup_d       = sops_pkg::STAT_TOO_MANY;
          seg_first_d   = 34'd0;
          seg_entries_d = '0;
        end else if (err_large) begin
          setup_d       = sops_pkg::STAT_TOO_LARGE;
          seg_first_d   = 34'd0;
          seg_entries_d = '0;
        end else begin
          setup_d       = sops_pkg::STAT_OK;
          seg_first_d   = lo_odd;
          seg_entries_d = Ew'(ent_val);
        end
        res_status_d = setup_d;
      end
      sops_pkg::ST_CLEAR: begin
        if (idx_lt_ent) begin
          mem_we = 1'b1;
          idx_d  = idx_q + 33'd1;
        end
      end
      sops_pkg::ST_SK_CHK: begin
        if (prime_bad) begin
          idx_d = 33'(scan_pos_q) + 33'd1;
        end else if (34'(pp) > seg_first_q) begin
          idx_d = 33'((34'(pp) - seg_first_q) >> 1);
        end
      end
      sops_pkg::ST_SK_DIV: if (div_rsp.done) idx_d = 33'(first_div);
      sops_pkg::ST_SK_MARK: begin
        if (idx_lt_ent) begin
          mem_we    = 1'b1;
          mem_wdata = 1'b1;
          idx_d     = idx_q + 33'(prime_q);
        end else begin
          idx_d = 33'(scan_pos_q) + 33'd1;
        end
      end
      sops_pkg::ST_SC_CHK: begin
        if (!idx_lt_ent) begin
          scan_pos_d   = seg_entries_q;
          res_status_d = sops_pkg::STAT_OVERRUN;
        end
      end
      sops_pkg::ST_SC_WAIT: begin
        if (mem_rd_q) begin
          idx_d = idx_q + 33'd1;
        end else begin
          scan_pos_d = idx_q[Ew-1:0];
          np_d       = {idx_q[16:0], 1'b1} + 18'd2;
        end
      end
      sops_pkg::ST_SC_KEEP: begin
        res_next_d = 32'(np_q);
        res_keep_d = np_sq <= 36'(limit_q);
      end
      sops_pkg::ST_CN_CHK: begin
        if (!idx_lt_ent) res_count_d = count_q + (node0 ? 32'd1 : 32'd0);
      end
      sops_pkg::ST_CN_WAIT: begin
        if (!mem_rd_q) count_d = count_q + 32'd1;
        idx_d = idx_q + 33'd1;
      end
      default: ;
    endcase
  end

  assign mem_addr    = idx_q[Aw-1:0];
  assign out_valid_d = out_load ? 1'b1 : ((out_valid_q && !out_stall_i) ? 1'b0 : out_valid_q);

  // ---------------------------------------------------------------- mark memory
  always_ff @(posedge clk_i) begin
    if (mem_we) mark_mem[mem_addr] <= mem_wdata;
    mem_rd_q <= mark_mem[mem_addr];
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= sops_pkg::ST_IDLE;
      div_run_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      setup_q       <= sops_pkg::STAT_OK;
      seg_first_q   <= 34'd0;
      seg_entries_q <= '0;
      scan_pos_q    <= '0;
    end else begin
      state_q       <= state_d;
      div_run_q     <= div_run_d;
      out_valid_q   <= out_valid_d;
      setup_q       <= setup_d;
      seg_first_q   <= seg_first_d;
      seg_entries_q <= seg_entries_d;
      scan_pos_q    <= scan_pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prime_q      <= prime_d;
    q0_q         <= q0_d;
    q1_q         <= q1_d;
    q2_q         <= q2_d;
    sqrt_q       <= sqrt_d;
    bit_q        <= bit_d;
    idx_q        <= idx_d;
    count_q      <= count_d;
    np_q         <= np_d;
    res_status_q <= res_status_d;
    res_next_q   <= res_next_d;
    res_keep_q   <= res_keep_d;
    res_count_q  <= res_count_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_next_q   <= res_next_q;
      out_keep_q   <= res_keep_q;
      out_count_q  <= res_count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign next_prime_o  = out_next_q;
  assign keep_going_o  = out_keep_q;
  assign prime_count_o = out_count_q;

`ifndef NO_ASSERTIONS
  a_entries_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_entries_q <= Ew'(sops_pkg::MarkEntries))
    else $error("segment larger than mark memory");

  a_error_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    setup_q != sops_pkg::STAT_OK |-> seg_entries_q == '0)
    else $error("setup error with nonempty segment");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_pos_q <= seg_entries_q)
    else $error("scan position past segment end");

  a_write_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> idx_q < 33'(seg_entries_q))
    else $error("mark write outside segment");

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> div_run_q)
    else $error("divider finished without a request");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for segmented_odd_prime_sieve
// holds a small sieve predictor in a class and drives the block with plain tasks
// depends on sops_pkg and the block's rtl
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] FuncReserved = 2'd3;
  localparam int ItemTarget = 580;
  localparam int CycleLimit = 4000000;

  typedef struct {
    sops_pkg::status_e status;
    logic [31:0]       next_prime;
    logic              keep_going;
    logic [31:0]       prime_count;
  } sieve_result_t;

  class sieve_board;
    bit                marks[sops_pkg::MarkEntries];
    longint unsigned   first_value;
    int unsigned       entries;
    int unsigned       scan_pos;
    sops_pkg::status_e setup = sops_pkg::STAT_OK;
    int unsigned       limit_n = 100;
    int unsigned       node_idx = 0;
    int unsigned       node_cnt = 1;
    sieve_result_t     pending[$];
    int                errors = 0;
    int                checked = 0;

    function longint unsigned isqrt(longint unsigned v);
      longint unsigned r, c;
      r = 0;
      for (int b = 15; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if (c * c <= v) r = c;
      end
      return r;
    endfunction

    function void open_segment();
      longint unsigned n, m, p, id, lo, hi, e;
      n = limit_n;
      m = (n >= 1) ? n - 1 : 0;
      p = (node_cnt == 0) ? 1 : node_cnt;
      id = node_idx;
      e = 0;
      foreach (marks[i]) marks[i] = 0;
      scan_pos = 0;
      entries = 0;
      first_value = 0;
      if (id >= p || 2 + m / p < isqrt(n)) begin
        setup = sops_pkg::STAT_TOO_MANY;
        return;
      end
      lo = 2 + id * m / p;
      hi = 2 + (id + 1) * m / p;
      if (lo[0] == 1'b0) lo++;
      if (hi > lo) e = (hi - lo + 1) / 2;
      if (e > sops_pkg::MarkEntries) begin
        setup = sops_pkg::STAT_TOO_LARGE;
        return;
      end
      setup = sops_pkg::STAT_OK;
      first_value = lo;
      entries = e;
    endfunction

    function void strike_multiples(longint unsigned p);
      longint unsigned lo, first, r;
      lo = first_value;
      if (p < 3 || p[0] == 1'b0) return;
      if (p * p > lo) first = (p * p - lo) / 2;
      else begin
        r = lo % p;
        if (r == 0) first = 0;
        else if (((lo / p) & 1) != 0) first = (2 * p - r) / 2;
        else first = (p - r) / 2;
      end
      for (longint unsigned i = first; i < entries; i += p) marks[i] = 1;
    endfunction

    function sieve_result_t note_item(logic [1:0] f, logic [15:0] p);
      sieve_result_t   r;
      int unsigned     k;
      longint unsigned np;
      r.status = setup;
      r.next_prime = 0;
      r.keep_going = 0;
      r.prime_count = 0;
      case (f)
        sops_pkg::FUNC_START: begin
          open_segment();
          r.status = setup;
          r.next_prime = (node_idx == 0) ? 32'd3 : 32'd0;
          r.keep_going = 1;
        end
        sops_pkg::FUNC_STRIKE: begin
          if (setup == sops_pkg::STAT_OK) begin
            strike_multiples(p);
            if (node_idx == 0) begin
              k = scan_pos + 1;
              while (k < entries && marks[k]) k++;
              if (k >= entries) begin
                scan_pos = entries;
                r.status = sops_pkg::STAT_OVERRUN;
              end else begin
                np = longint'(k) * 2 + 3;
                scan_pos = k;
                r.next_prime = np[31:0];
                r.keep_going = (np * np <= limit_n);
              end
            end
          end
        end
        sops_pkg::FUNC_COUNT: begin
          if (setup == sops_pkg::STAT_OK) begin
            for (int unsigned i = 0; i < entries; i++)
              if (!marks[i]) r.prime_count++;
            if (node_idx == 0) r.prime_count++;
          end
        end
        default: ;
      endcase
      pending.push_back(r);
      return r;
    endfunction

    function void check_result(logic [1:0] st, logic [31:0] np, logic kg, logic [31:0] pc);
      sieve_result_t e;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: result beat with nothing expected", $time);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
      if (np !== e.next_prime) begin
        $display("%0t: next_prime expected %0d actual %0d", $time, e.next_prime, np);
        errors++;
      end
      if (kg !== e.keep_going) begin
        $display("%0t: keep_going expected %0d actual %0d", $time, e.keep_going, kg);
        errors++;
      end
      if (pc !== e.prime_count) begin
        $display("%0t: prime_count expected %0d actual %0d", $time, e.prime_count, pc);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [1:0]  func_i = '0;
  logic [15:0] sieve_prime_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic [1:0]  status_o;
  logic [31:0] next_prime_o;
  logic        keep_going_o;
  logic [31:0] prime_count_o;

  segmented_odd_prime_sieve dut (.*);

  always #2 clk_i = ~clk_i;

  sieve_board    board;
  sieve_result_t last_res;
  int            sent_cnt = 0;
  int            phase_cnt = 0;
  int            hold_left = 0;
  bit            hold_done = 0;
  int            cycles = 0;

  function int send_idle_pct();
    if (sent_cnt < ItemTarget / 3) return 8;
    if (sent_cnt < 2 * ItemTarget / 3) return 58;
    return 0;
  endfunction

  function int recv_stall_pct();
    if (sent_cnt < ItemTarget / 3) return 58;
    if (sent_cnt < 2 * ItemTarget / 3) return 8;
    return 0;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("run hit the cycle limit");
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: check beats, stall at random, one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result(status_o, next_prime_o, keep_going_o, prime_count_o);
    if (!hold_done && sent_cnt >= 60 && hold_left == 0) begin
      hold_left = 600;
      hold_done = 1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct());
    end
  end

  task automatic send_item(logic [1:0] f, logic [15:0] p);
    if ($urandom_range(0, 99) < send_idle_pct()) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    sieve_prime_i <= p;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    last_res = board.note_item(f, p);
    sent_cnt++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(sops_pkg::cfg_e idx, logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      sops_pkg::CFG_LIMIT:      board.limit_n = data;
      sops_pkg::CFG_NODE_INDEX: board.node_idx = data[7:0];
      default:                  board.node_cnt = data[8:0];
    endcase
  endtask

  function automatic int next_odd_prime(int v);
    bit comp;
    do begin
      v += 2;
      comp = 0;
      for (int d = 3; d * d <= v; d += 2)
        if (v % d == 0) comp = 1;
    end while (comp);
    return v;
  endfunction

  // one setting: start, a sieve pass with some noise, then a count
  task automatic run_phase(logic [31:0] lim, int idx, int cnt, int max_strikes, int noise_pct);
    int p;
    int n;
    drain();
    write_reg(sops_pkg::CFG_LIMIT, lim);
    write_reg(sops_pkg::CFG_NODE_INDEX, idx[31:0]);
    write_reg(sops_pkg::CFG_NODE_COUNT, cnt[31:0]);
    phase_cnt++;
    send_item(sops_pkg::FUNC_START, 16'($urandom));
    p = 3;
    n = 0;
    while (n < max_strikes && longint'(p) * p <= lim && p < 65536) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_item(2'($urandom_range(0, 3)), 16'($urandom));
      else begin
        send_item(sops_pkg::FUNC_STRIKE, p[15:0]);
        n++;
        if (board.node_idx == 0 && last_res.status == sops_pkg::STAT_OK &&
            last_res.next_prime > p)
          p = last_res.next_prime;
        else
          p = next_odd_prime(p);
      end
    end
    send_item(sops_pkg::FUNC_COUNT, 16'($urandom));
  endtask

  initial begin
    int c, i;
    logic [31:0] lim;
    board = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // before any start: empty segment
    send_item(sops_pkg::FUNC_STRIKE, 16'd3);
    send_item(sops_pkg::FUNC_COUNT, 16'hffff);
    send_item(FuncReserved, 16'h0000);
    // reset settings, full pass over 100
    run_phase(32'd100, 0, 1, 10, 0);
    send_item(sops_pkg::FUNC_STRIKE, 16'd2);
    send_item(sops_pkg::FUNC_STRIKE, 16'd1);
    send_item(sops_pkg::FUNC_STRIKE, 16'hffff);
    send_item(FuncReserved, 16'hffff);
    run_phase(32'd3, 0, 1, 2, 0);
    run_phase(32'hffffffff, 255, 256, 1, 0);
    run_phase(32'd70000, 255, 256, 3, 0);
    run_phase(32'd500, 3, 2, 2, 0);
    run_phase(32'd500, 0, 0, 4, 0);
    run_phase(32'd131073, 0, 1, 3, 0);
    run_phase(32'd131075, 0, 1, 1, 0);

    while (sent_cnt < ItemTarget) begin
      case ($urandom_range(0, 19))
        0: run_phase($urandom, $urandom_range(0, 255), $urandom_range(1, 256), 2, 30);
        1: begin
          c = $urandom_range(1, 8);
          run_phase($urandom_range(3, 2000), $urandom_range(c, 255), c, 2, 30);
        end
        2: run_phase($urandom_range(3, 3000), 0, 0, 12, 15);
        default: begin
          c = $urandom_range(1, 4);
          i = $urandom_range(0, c - 1);
          lim = $urandom_range(3, 1500 * c);
          run_phase(lim, i, c, 14, 15);
        end
      endcase
    end
    drain();

    $display("sent %0d items in %0d settings, checked %0d results, %0d mismatches",
             sent_cnt, phase_cnt, board.checked, board.errors);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
